>>> rtl/vn_pkg.sv
// Package: shared types and constants for the vector normalizer.
package vn_pkg;

    localparam int IN_W   = 16;
    localparam int FRAC_W = 14;
    localparam int UNIT_W = FRAC_W + 2;
    localparam int MAG_W  = IN_W;              // magnitude of a component, up to 2^(IN_W-1)
    localparam int SUM_W  = 2 * IN_W + 1;      // sum of three squares
    localparam int LEN_W  = IN_W + 1;          // root of SUM_W bits
    localparam int NUM_W  = MAG_W + FRAC_W;    // dividend width
    localparam int QUO_W  = FRAC_W + 1;        // quotient, at most 2^FRAC_W

    typedef struct packed {
        logic signed [IN_W-1:0] vec_x;
        logic signed [IN_W-1:0] vec_y;
        logic signed [IN_W-1:0] vec_z;
    } t_req;

    typedef struct packed {
        logic signed [UNIT_W-1:0] unit_x;
        logic signed [UNIT_W-1:0] unit_y;
        logic signed [UNIT_W-1:0] unit_z;
        logic        [IN_W-1:0]   vec_length;
        logic                     zero_vector;
    } t_rsp;

    // Classified request handed from front to back.
    typedef struct packed {
        logic [2:0][MAG_W-1:0] mag;
        logic [2:0]            neg;
        logic [SUM_W-1:0]      sum;
    } t_cls;

endpackage

>>> rtl/vector3_normalize.sv
// Top level: 3D vector normalizer, one request per cycle while full is low.
// Path to earliest pop: front, mid queue, root, divide, result memory, output register.
// Throughput: one request per cycle unless full; root and divide units are fully pipelined.
// full rises once in-flight plus queued requests reach QDEPTH-1 or in-flight reach INFL,
// so nothing overflows.
// Synchronous active-low reset clears valid bits, counters and queue pointers only.
module vector3_normalize #(
    parameter int QDEPTH = 64
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          push,
    output logic          full,
    input  vn_pkg::t_req  i_req,
    output logic          empty,
    input  logic          pop,
    output vn_pkg::t_rsp  o_rsp
);

    localparam int INFL = 40;  // more than the pipeline depth
    localparam int MQD  = 4;   // mid queue depth

    logic              w_fv, w_bv, w_qe, w_qpop;
    vn_pkg::t_cls      w_cls, w_qcls;
    logic [$clog2(MQD+1)-1:0] w_cnt;
    vn_pkg::t_rsp      w_rsp;
    logic              w_in;

    assign w_in = push && !full;

    vn_front u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(w_in), .i_req(i_req),
        .i_stall(1'b0), .o_valid(w_fv), .o_cls(w_cls)
    );

    vn_fifo #(.DEPTH(MQD)) u_q (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_push(w_fv), .i_data(w_cls),
        .i_pop(w_qpop), .o_empty(w_qe), .o_count(w_cnt), .o_data(w_qcls)
    );

    assign w_qpop = !w_qe;

    vn_back u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(w_qpop), .i_cls(w_qcls),
        .i_stall(1'b0), .o_valid(w_bv), .o_rsp(w_rsp)
    );

    // Result queue: memory with registered read into the output register.
    vn_pkg::t_rsp                    r_omem [QDEPTH];
    logic [$clog2(QDEPTH)-1:0]       r_owp, r_orp;
    logic [$clog2(QDEPTH+1)-1:0]     r_mcnt, r_infl;
    logic                            r_ov;
    vn_pkg::t_rsp                    r_out;
    logic                            w_orea, w_mrd;

    assign w_orea = pop && r_ov;
    assign w_mrd  = (r_mcnt != '0) && (!r_ov || w_orea);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_owp  <= '0;
            r_orp  <= '0;
            r_mcnt <= '0;
            r_infl <= '0;
            r_ov   <= 1'b0;
        end else begin
            if (w_bv) r_owp <= r_owp + 1'b1;
            if (w_mrd) r_orp <= r_orp + 1'b1;
            r_mcnt <= r_mcnt + (w_bv ? 1'b1 : 1'b0) - (w_mrd ? 1'b1 : 1'b0);
            r_infl <= r_infl + (w_in ? 1'b1 : 1'b0) - (w_bv ? 1'b1 : 1'b0);
            if (w_mrd) begin
                r_ov <= 1'b1;
            end else if (w_orea) begin
                r_ov <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_bv) r_omem[r_owp] <= w_rsp;
        if (w_mrd) r_out <= r_omem[r_orp];
    end

    assign o_rsp = r_out;
    assign empty = !r_ov;
    assign full  = (32'(r_infl) + 32'(r_mcnt) + 32'(r_ov) + 32'(w_cnt) >= 32'(QDEPTH - 1))
                || (32'(r_infl) >= 32'(INFL));

`ifndef SYNTHESIS
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_bv |-> r_mcnt != ($clog2(QDEPTH+1))'(QDEPTH))
        else $error("result queue overflow");
    a_fill_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_mcnt != '0 |=> !empty)
        else $error("output register not refilled");
    a_pop_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_orea && !w_mrd |=> empty)
        else $error("output register not cleared on pop");
`endif

endmodule

>>> rtl/vn_front.sv
// Front part: component magnitudes and the sum of squares, two stages.
module vn_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    input  vn_pkg::t_req      i_req,
    input  logic              i_stall,
    output logic              o_valid,
    output vn_pkg::t_cls      o_cls
);

    logic [1:0]                          r_vld;
    logic [2:0][vn_pkg::MAG_W-1:0]       r_mag, r_mag2;
    logic [2:0]                          r_neg, r_neg2;
    logic [2:0][2*vn_pkg::MAG_W-1:0]     r_sq;
    logic [vn_pkg::SUM_W-1:0]            r_sum;
    logic [vn_pkg::SUM_W-1:0]            n_sum;
    logic [2:0][vn_pkg::IN_W-1:0]        w_in;
    logic [2:0][vn_pkg::MAG_W-1:0]       w_mag;

    assign w_in = {i_req.vec_z, i_req.vec_y, i_req.vec_x};
    assign n_sum = vn_pkg::SUM_W'(r_sq[0]) + vn_pkg::SUM_W'(r_sq[1])
                 + vn_pkg::SUM_W'(r_sq[2]);

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            w_mag[i] = w_in[i][vn_pkg::IN_W-1] ? (~w_in[i] + 1'b1) : w_in[i];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (!i_stall) begin
            r_vld <= {r_vld[0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_stall) begin
            for (int i = 0; i < 3; i++) begin
                r_neg[i] <= w_in[i][vn_pkg::IN_W-1];
                r_mag[i] <= w_mag[i];
                r_sq[i]  <= w_mag[i] * w_mag[i];
            end
            r_mag2 <= r_mag;
            r_neg2 <= r_neg;
            r_sum  <= n_sum;
        end
    end

    assign o_valid = r_vld[1];
    assign o_cls   = '{mag: r_mag2, neg: r_neg2, sum: r_sum};

endmodule

>>> rtl/vn_fifo.sv
// Short queue between front and back parts.
module vn_fifo #(
    parameter int DEPTH = 8
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  vn_pkg::t_cls  i_data,
    input  logic          i_pop,
    output logic          o_empty,
    output logic [$clog2(DEPTH+1)-1:0] o_count,
    output vn_pkg::t_cls  o_data
);

    localparam int AW = $clog2(DEPTH);

    vn_pkg::t_cls           r_mem [DEPTH];
    logic [AW-1:0]          r_wp, r_rp;
    logic [$clog2(DEPTH+1)-1:0] r_cnt;
    logic                   w_wr, w_rd;

    assign w_rd = i_pop && (r_cnt != '0);
    assign w_wr = i_push;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp <= '0;
            r_rp <= '0;
            r_cnt <= '0;
        end else begin
            if (w_wr) r_wp <= (r_wp == AW'(DEPTH-1)) ? '0 : r_wp + 1'b1;
            if (w_rd) r_rp <= (r_rp == AW'(DEPTH-1)) ? '0 : r_rp + 1'b1;
            r_cnt <= r_cnt + (w_wr ? 1'b1 : 1'b0) - (w_rd ? 1'b1 : 1'b0);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_wr) r_mem[r_wp] <= i_data;
    end

    assign o_data  = r_mem[r_rp];
    assign o_empty = (r_cnt == '0);
    assign o_count = r_cnt;

endmodule

>>> rtl/vn_back.sv
// Back part: pipelined square root and three pipelined dividers.
module vn_back (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    input  vn_pkg::t_cls  i_cls,
    input  logic          i_stall,
    output logic          o_valid,
    output vn_pkg::t_rsp  o_rsp
);

    localparam int RS = vn_pkg::LEN_W;    // root steps, one bit each
    localparam int DS = vn_pkg::QUO_W;    // divide steps, one bit each
    localparam int RW = vn_pkg::SUM_W + 1;
    localparam int NW = vn_pkg::NUM_W;
    localparam int LW = vn_pkg::LEN_W;
    localparam int MW = vn_pkg::MAG_W;
    localparam int SW = vn_pkg::SUM_W;

    // root stage registers
    logic [RS:1]                r_rv;
    logic [RS-1:1][RW-1:0]      r_rem;
    logic [RS:1][LW-1:0]        r_root;
    logic [RS:1][2:0][MW-1:0]   r_rmag;
    logic [RS:1][2:0]           r_rneg;
    logic [RS:1]                r_rzero;
    logic [RS-1:1][SW-1:0]      r_rsum;

    // root stage inputs
    logic [RS-1:0]              w_rsv;
    logic [RS-1:0][RW-1:0]      w_rsrem;
    logic [RS-1:0][LW-1:0]      w_rsroot;
    logic [RS-1:0][2:0][MW-1:0] w_rsmag;
    logic [RS-1:0][2:0]         w_rsneg;
    logic [RS-1:0]              w_rszero;
    logic [RS-1:0][SW-1:0]      w_rssum;
    logic [RS-1:0][RW-1:0]      w_rem, w_trial;
    logic [RS-1:0][LW-1:0]      w_root;
    logic [RS-1:0]              w_rge;

    always_comb begin
        w_rsv[0]    = i_valid;
        w_rsrem[0]  = '0;
        w_rsroot[0] = '0;
        w_rsmag[0]  = i_cls.mag;
        w_rsneg[0]  = i_cls.neg;
        w_rszero[0] = (i_cls.sum == '0);
        w_rssum[0]  = i_cls.sum;
        for (int s = 1; s < RS; s++) begin
            w_rsv[s]    = r_rv[s];
            w_rsrem[s]  = r_rem[s];
            w_rsroot[s] = r_root[s];
            w_rsmag[s]  = r_rmag[s];
            w_rsneg[s]  = r_rneg[s];
            w_rszero[s] = r_rzero[s];
            w_rssum[s]  = r_rsum[s];
        end
        for (int s = 0; s < RS; s++) begin
            w_rem[s]   = {w_rsrem[s][RW-3:0], 2'b00}
                       | ((RW'(w_rssum[s]) >> (2 * (RS - 1 - s))) & RW'(3));
            w_root[s]  = {w_rsroot[s][LW-2:0], 1'b0};
            w_trial[s] = RW'({w_root[s], 1'b1});
            w_rge[s]   = (w_rem[s] >= w_trial[s]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rv <= '0;
        end else if (!i_stall) begin
            r_rv <= w_rsv;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_stall) begin
            for (int s = 0; s < RS; s++) begin
                r_root[s+1] <= w_rge[s] ? (w_root[s] | LW'(1)) : w_root[s];
            end
            for (int s = 0; s < RS - 1; s++) begin
                r_rem[s+1] <= w_rge[s] ? (w_rem[s] - w_trial[s]) : w_rem[s];
            end
            r_rmag  <= w_rsmag;
            r_rneg  <= w_rsneg;
            r_rzero <= w_rszero;
            r_rsum  <= w_rssum[RS-2:0];
        end
    end

    // divide stage registers; length kept nonzero for the zero case
    logic [DS:1]                r_dv;
    logic [DS-1:1][2:0][NW-1:0] r_num;
    logic [DS-1:1][2:0][LW:0]   r_drem;
    logic [DS:1][2:0][DS-1:0]   r_quo;
    logic [DS:1][2:0]           r_dneg;
    logic [DS:1]                r_dzero;
    logic [DS:1][LW-1:0]        r_len;

    // divide stage inputs
    logic [DS-1:0]              w_dsv;
    logic [DS-1:0][2:0][NW-1:0] w_dsnum;
    logic [DS-1:0][2:0][DS-1:0] w_dsquo;
    logic [DS-1:0][2:0]         w_dsneg;
    logic [DS-1:0]              w_dszero;
    logic [DS-1:0][LW-1:0]      w_dslen;
    logic [DS-1:0][2:0][LW:0]   w_r;
    logic [DS-1:0][2:0]         w_dge;

    // Quotient < 2^DS since mag <= len; the dividend's bits from DS-1 upward
    // are folded into the first partial remainder.
    always_comb begin
        w_dsv[0]    = r_rv[RS];
        w_dsneg[0]  = r_rneg[RS];
        w_dszero[0] = r_rzero[RS];
        w_dslen[0]  = r_rzero[RS] ? LW'(1) : r_root[RS];
        w_dsquo[0]  = '0;
        for (int c = 0; c < 3; c++) begin
            w_dsnum[0][c] = {r_rmag[RS][c], vn_pkg::FRAC_W'(0)};
        end
        for (int s = 1; s < DS; s++) begin
            w_dsv[s]    = r_dv[s];
            w_dsnum[s]  = r_num[s];
            w_dsquo[s]  = r_quo[s];
            w_dsneg[s]  = r_dneg[s];
            w_dszero[s] = r_dzero[s];
            w_dslen[s]  = r_len[s];
        end
        for (int c = 0; c < 3; c++) begin
            w_r[0][c] = (LW+1)'(w_dsnum[0][c] >> (DS - 1));
        end
        for (int s = 1; s < DS; s++) begin
            for (int c = 0; c < 3; c++) begin
                w_r[s][c] = {r_drem[s][c][LW-1:0], w_dsnum[s][c][DS-1-s]};
            end
        end
        for (int s = 0; s < DS; s++) begin
            for (int c = 0; c < 3; c++) begin
                w_dge[s][c] = (w_r[s][c] >= (LW+1)'(w_dslen[s]));
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dv <= '0;
        end else if (!i_stall) begin
            r_dv <= w_dsv;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_stall) begin
            for (int s = 0; s < DS; s++) begin
                for (int c = 0; c < 3; c++) begin
                    r_quo[s+1][c] <= {w_dsquo[s][c][DS-2:0], w_dge[s][c]};
                end
            end
            for (int s = 0; s < DS - 1; s++) begin
                for (int c = 0; c < 3; c++) begin
                    r_drem[s+1][c] <= w_dge[s][c] ? (w_r[s][c] - (LW+1)'(w_dslen[s]))
                                                  : w_r[s][c];
                end
            end
            r_num   <= w_dsnum[DS-2:0];
            r_dneg  <= w_dsneg;
            r_dzero <= w_dszero;
            r_len   <= w_dslen;
        end
    end

    logic [2:0][vn_pkg::UNIT_W-1:0] w_unit;
    always_comb begin
        for (int c = 0; c < 3; c++) begin
            if (r_dzero[DS])
                w_unit[c] = '0;
            else if (r_dneg[DS][c])
                w_unit[c] = vn_pkg::UNIT_W'(0) - vn_pkg::UNIT_W'(r_quo[DS][c]);
            else
                w_unit[c] = vn_pkg::UNIT_W'(r_quo[DS][c]);
        end
        o_rsp.unit_x      = w_unit[0];
        o_rsp.unit_y      = w_unit[1];
        o_rsp.unit_z      = w_unit[2];
        o_rsp.vec_length  = r_dzero[DS] ? '0 : r_len[DS][vn_pkg::IN_W-1:0];
        o_rsp.zero_vector = r_dzero[DS];
    end
    assign o_valid = r_dv[DS];

`ifndef SYNTHESIS
    a_zero_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_rsp.zero_vector |-> o_rsp.vec_length == '0)
        else $error("zero vector with nonzero length");
    a_unit_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> r_quo[DS][0] <= DS'(1 << vn_pkg::FRAC_W))
        else $error("unit quotient above one");
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_stall |=> $stable(r_dv))
        else $error("pipeline moved during stall");
`endif

endmodule
